>>> src/symint_pkg.sv
`default_nettype none
package symint_pkg;

  localparam int TABLE_SLOTS_DEF    = 256;
  localparam int MAX_NAME_BYTES_DEF = 64;
  localparam int HASH_W             = 32;
  localparam int LIMIT_W            = 9;
  localparam int SLOT_OUT_W         = 8;

  localparam logic [HASH_W-1:0]  FNV_BASIS   = 32'h811C_9DC5;
  localparam logic [HASH_W-1:0]  FNV_PRIME   = 32'h0100_0193;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd192;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  function automatic int addr_w(input int depth);
    addr_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

>>> src/symint_ram.sv
`default_nettype none
module symint_ram
  import symint_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [addr_w(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [addr_w(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/symint_hash.sv
`default_nettype none
module symint_hash
  import symint_pkg::*;
#(
  parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEF,
  parameter int LEN_W          = $clog2(MAX_NAME_BYTES + 2)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire logic [7:0]                        name_byte,
  input  wire logic                              byte_present,
  input  wire logic                              last_byte,
  output logic      [HASH_W-1:0]                 hash_fin,
  output logic      [LEN_W-1:0]                  len_fin,
  output logic                                   pend_we,
  output logic      [addr_w(MAX_NAME_BYTES)-1:0] pend_waddr
);

  logic [HASH_W-1:0] hash_r, hash_nxt, hash_step;
  logic [LEN_W-1:0]  len_r, len_nxt;

  assign hash_step  = HASH_W'((hash_r ^ {24'd0, name_byte}) * FNV_PRIME);
  assign hash_fin   = byte_present ? hash_step : hash_r;
  assign len_fin    = (byte_present && (len_r <= LEN_W'(MAX_NAME_BYTES))) ?
                      len_r + LEN_W'(1) : len_r;
  assign pend_we    = accept && byte_present && (len_r < LEN_W'(MAX_NAME_BYTES));
  assign pend_waddr = len_r[addr_w(MAX_NAME_BYTES)-1:0];

  always_comb begin
    hash_nxt = hash_r;
    len_nxt  = len_r;
    if (accept) begin
      if (last_byte) begin
        hash_nxt = FNV_BASIS;
        len_nxt  = '0;
      end else begin
        hash_nxt = hash_fin;
        len_nxt  = len_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      len_r  <= '0;
    end else begin
      hash_r <= hash_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/symint_probe.sv
`default_nettype none
module symint_probe
  import symint_pkg::*;
#(
  parameter int TABLE_SLOTS    = TABLE_SLOTS_DEF,
  parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEF,
  parameter int LEN_W          = $clog2(MAX_NAME_BYTES + 2),
  parameter int SLOT_W         = addr_w(TABLE_SLOTS),
  parameter int BYTE_AW        = addr_w(TABLE_SLOTS * MAX_NAME_BYTES),
  parameter int PEND_AW        = addr_w(MAX_NAME_BYTES)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic [HASH_W-1:0]         hash_in,
  input  wire logic [LEN_W-1:0]          len_in,
  input  wire logic [LIMIT_W-1:0]        insert_limit,
  output logic                           busy,
  output logic                           meta_we,
  output logic      [SLOT_W-1:0]         meta_addr,
  output logic      [HASH_W+LEN_W-1:0]   meta_wdata,
  input  wire logic [HASH_W+LEN_W-1:0]   meta_rdata,
  output logic      [PEND_AW-1:0]        pend_raddr,
  input  wire logic [7:0]                pend_rdata,
  output logic                           byte_we,
  output logic      [BYTE_AW-1:0]        byte_addr,
  input  wire logic [7:0]                byte_rdata,
  output logic                           res_valid,
  output logic      [SLOT_OUT_W-1:0]     res_slot,
  output status_t                        res_status,
  output logic      [HASH_W-1:0]         res_hash
);

  localparam int  CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int  SWP_W   = $clog2(TABLE_SLOTS + 1);
  localparam bit  IS_POW2 = ((1 << SLOT_W) == TABLE_SLOTS);
  localparam int  PROD_W  = 2 * HASH_W + 1;
  localparam int  SHIFT   = HASH_W + SLOT_W;

  // The slot is hash mod slots, taken by a multiply with the rounded-up reciprocal.
  localparam logic [PROD_W-1:0] RECIP_FULL =
    ((PROD_W'(1) << SHIFT) + PROD_W'(TABLE_SLOTS) - PROD_W'(1)) / PROD_W'(TABLE_SLOTS);
  localparam logic [HASH_W-1:0] RECIP_LO = RECIP_FULL[HASH_W-1:0];
  localparam bit                RECIP_HI = RECIP_FULL[HASH_W];

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_MOD     = 8'b0000_0010,
    S_PROBE   = 8'b0000_0100,
    S_CHECK   = 8'b0000_1000,
    S_CMP_RD  = 8'b0001_0000,
    S_CMP_CK  = 8'b0010_0000,
    S_COPY_RD = 8'b0100_0000,
    S_COPY_WR = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt, slot_inc;
  logic [PROD_W-1:0]   prod_r, prod_nxt, prod_sum;
  logic [HASH_W-1:0]   quo_r, quo_nxt;
  logic [1:0]          mstep_r, mstep_nxt;
  logic [SWP_W-1:0]    sweep_r, sweep_nxt;
  logic [LEN_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                valid_r [TABLE_SLOTS];
  logic                set_valid;
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [HASH_W-1:0]   out_hash_r, out_hash_nxt;
  logic                room;
  logic                idx_last;

  assign busy       = (state_r != S_IDLE);
  assign meta_addr  = slot_r;
  assign meta_wdata = {hash_r, len_r};
  assign pend_raddr = idx_r[PEND_AW-1:0];
  assign byte_addr  = BYTE_AW'(slot_r) * BYTE_AW'(MAX_NAME_BYTES) + BYTE_AW'(idx_r);
  assign res_valid  = out_valid_r;
  assign res_slot   = out_slot_r;
  assign res_status = out_status_r;
  assign res_hash   = out_hash_r;

  assign slot_inc  = (32'(slot_r) == TABLE_SLOTS - 1) ? '0 : slot_r + SLOT_W'(1);
  assign prod_sum  = prod_r + (RECIP_HI ? {1'b0, hash_r, {HASH_W{1'b0}}} : PROD_W'(0));
  assign room      = 32'(count_r) < 32'(insert_limit);
  assign idx_last  = (idx_r + LEN_W'(1)) == len_r;

  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    len_nxt        = len_r;
    slot_nxt       = slot_r;
    prod_nxt       = prod_r;
    quo_nxt        = quo_r;
    mstep_nxt      = mstep_r;
    sweep_nxt      = sweep_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    set_valid      = 1'b0;
    meta_we        = 1'b0;
    byte_we        = 1'b0;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_hash_nxt   = out_hash_r;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          hash_nxt  = hash_in;
          len_nxt   = len_in;
          sweep_nxt = '0;
          if (len_in > LEN_W'(MAX_NAME_BYTES)) begin
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = '0;
            out_status_nxt = ST_TOO_LONG;
            out_hash_nxt   = hash_in;
          end else if (IS_POW2) begin
            slot_nxt  = hash_in[SLOT_W-1:0];
            state_nxt = S_PROBE;
          end else begin
            mstep_nxt = '0;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        mstep_nxt = mstep_r + 2'd1;
        case (mstep_r)
          2'd0: prod_nxt = PROD_W'(64'(hash_r) * 64'(RECIP_LO));
          2'd1: quo_nxt = HASH_W'(prod_sum >> SHIFT);
          2'd2: quo_nxt = HASH_W'(quo_r * HASH_W'(TABLE_SLOTS));
          default: begin
            slot_nxt  = SLOT_W'(hash_r - quo_r);
            state_nxt = S_PROBE;
          end
        endcase
      end
      S_PROBE: begin
        if (!valid_r[slot_r]) begin
          if (room) begin
            set_valid = 1'b1;
            meta_we   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            idx_nxt   = '0;
            if (len_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_slot_nxt   = SLOT_OUT_W'(slot_r);
              out_status_nxt = ST_INSERTED;
              out_hash_nxt   = hash_r;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_COPY_RD;
            end
          end else begin
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = '0;
            out_status_nxt = ST_FULL;
            out_hash_nxt   = hash_r;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (meta_rdata == {hash_r, len_r}) begin
          if (len_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = SLOT_OUT_W'(slot_r);
            out_status_nxt = ST_FOUND;
            out_hash_nxt   = hash_r;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_CMP_RD;
          end
        end else if (32'(sweep_r) == TABLE_SLOTS - 1) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = '0;
          out_status_nxt = ST_FULL;
          out_hash_nxt   = hash_r;
          state_nxt      = S_IDLE;
        end else begin
          slot_nxt  = slot_inc;
          sweep_nxt = sweep_r + SWP_W'(1);
          state_nxt = S_PROBE;
        end
      end
      S_CMP_RD: begin
        state_nxt = S_CMP_CK;
      end
      S_CMP_CK: begin
        if (pend_rdata != byte_rdata) begin
          if (32'(sweep_r) == TABLE_SLOTS - 1) begin
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = '0;
            out_status_nxt = ST_FULL;
            out_hash_nxt   = hash_r;
            state_nxt      = S_IDLE;
          end else begin
            slot_nxt  = slot_inc;
            sweep_nxt = sweep_r + SWP_W'(1);
            state_nxt = S_PROBE;
          end
        end else if (idx_last) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = SLOT_OUT_W'(slot_r);
          out_status_nxt = ST_FOUND;
          out_hash_nxt   = hash_r;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = idx_r + LEN_W'(1);
          state_nxt = S_CMP_RD;
        end
      end
      S_COPY_RD: begin
        state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        byte_we = 1'b1;
        if (idx_last) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = SLOT_OUT_W'(slot_r);
          out_status_nxt = ST_INSERTED;
          out_hash_nxt   = hash_r;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = idx_r + LEN_W'(1);
          state_nxt = S_COPY_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (set_valid) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hash_r       <= hash_nxt;
    len_r        <= len_nxt;
    slot_r       <= slot_nxt;
    prod_r       <= prod_nxt;
    quo_r        <= quo_nxt;
    mstep_r      <= mstep_nxt;
    sweep_r      <= sweep_nxt;
    idx_r        <= idx_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_hash_r   <= out_hash_nxt;
  end

endmodule
`default_nettype wire

>>> src/symbol_intern_hash_table.sv
// A byte item is taken when start is high and busy is low; busy stays low between bytes of a name.
// On the last item the probe sequencer runs: a probe and a check state per occupied
// slot probed, a probe state for the empty slot, a read and a check or write state
// per byte compared or copied, plus the hash reduction steps when the slot count is
// not a power of two. A name that is too long gives its result the next cycle. The
// result strobe lasts one cycle and the receiver cannot stall it.
// Reset is synchronous, active low; it clears the slot valid bits and counters.
`default_nettype none
module symbol_intern_hash_table
  import symint_pkg::*;
#(
  parameter int TABLE_SLOTS    = TABLE_SLOTS_DEF,
  parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [7:0]            in_name_byte,
  input  wire logic                  in_byte_present,
  input  wire logic                  in_last_byte,
  input  wire logic                  cfg_we,
  input  wire logic [LIMIT_W-1:0]    cfg_wdata,
  output logic                       out_valid,
  output logic [SLOT_OUT_W-1:0]      out_slot_index,
  output logic [1:0]                 out_status,
  output logic [HASH_W-1:0]          out_name_hash
);

  localparam int LEN_W   = $clog2(MAX_NAME_BYTES + 2);
  localparam int SLOT_W  = addr_w(TABLE_SLOTS);
  localparam int BYTE_AW = addr_w(TABLE_SLOTS * MAX_NAME_BYTES);
  localparam int PEND_AW = addr_w(MAX_NAME_BYTES);

  logic [LIMIT_W-1:0]      limit_r;
  logic                    accept;
  logic [HASH_W-1:0]       hash_fin;
  logic [LEN_W-1:0]        len_fin;
  logic                    pend_we;
  logic [PEND_AW-1:0]      pend_waddr, pend_raddr;
  logic [7:0]              pend_rdata;
  logic                    meta_we;
  logic [SLOT_W-1:0]       meta_addr;
  logic [HASH_W+LEN_W-1:0] meta_wdata, meta_rdata;
  logic                    byte_we;
  logic [BYTE_AW-1:0]      byte_addr;
  logic [7:0]              byte_rdata;
  status_t                 res_status;

  assign accept     = start && !busy;
  assign out_status = res_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  symint_hash #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES),
    .LEN_W(LEN_W)
  ) u_hash (
    .clk(clk),
    .rst_n(rst_n),
    .accept(accept),
    .name_byte(in_name_byte),
    .byte_present(in_byte_present),
    .last_byte(in_last_byte),
    .hash_fin(hash_fin),
    .len_fin(len_fin),
    .pend_we(pend_we),
    .pend_waddr(pend_waddr)
  );

  symint_ram #(.WIDTH(8), .DEPTH(MAX_NAME_BYTES)) u_pend_ram (
    .clk(clk),
    .we(pend_we),
    .waddr(pend_waddr),
    .wdata(in_name_byte),
    .raddr(pend_raddr),
    .rdata(pend_rdata)
  );

  symint_ram #(.WIDTH(HASH_W + LEN_W), .DEPTH(TABLE_SLOTS)) u_meta_ram (
    .clk(clk),
    .we(meta_we),
    .waddr(meta_addr),
    .wdata(meta_wdata),
    .raddr(meta_addr),
    .rdata(meta_rdata)
  );

  symint_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS * MAX_NAME_BYTES)) u_byte_ram (
    .clk(clk),
    .we(byte_we),
    .waddr(byte_addr),
    .wdata(pend_rdata),
    .raddr(byte_addr),
    .rdata(byte_rdata)
  );

  symint_probe #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .MAX_NAME_BYTES(MAX_NAME_BYTES),
    .LEN_W(LEN_W),
    .SLOT_W(SLOT_W),
    .BYTE_AW(BYTE_AW),
    .PEND_AW(PEND_AW)
  ) u_probe (
    .clk(clk),
    .rst_n(rst_n),
    .go(accept && in_last_byte),
    .hash_in(hash_fin),
    .len_in(len_fin),
    .insert_limit(limit_r),
    .busy(busy),
    .meta_we(meta_we),
    .meta_addr(meta_addr),
    .meta_wdata(meta_wdata),
    .meta_rdata(meta_rdata),
    .pend_raddr(pend_raddr),
    .pend_rdata(pend_rdata),
    .byte_we(byte_we),
    .byte_addr(byte_addr),
    .byte_rdata(byte_rdata),
    .res_valid(out_valid),
    .res_slot(out_slot_index),
    .res_status(res_status),
    .res_hash(out_name_hash)
  );

endmodule
`default_nettype wire

>>> src/symint_checker.sv
`default_nettype none
module symint_checker
  import symint_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  in_last_byte,
  input wire logic                  out_valid,
  input wire logic [SLOT_OUT_W-1:0] out_slot_index,
  input wire logic [1:0]            out_status
);

  a_last_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_byte |=> busy || out_valid)
    else $error("last beat neither started a lookup nor gave a result");

  a_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_byte |=> !out_valid)
    else $error("result without a last beat");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_error_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_TOO_LONG)
    |-> out_slot_index == '0)
    else $error("error result with non-zero slot");

endmodule

bind symbol_intern_hash_table symint_checker u_symint_checker (.*);
`default_nettype wire

>>> tb/sv/symbol_intern_hash_table_test.sv
`timescale 1ns / 100ps
`default_nettype none
module symbol_intern_hash_table_test;
  import symint_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int MAXLEN = MAX_NAME_BYTES_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       present;
    logic       last;
  } name_beat_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    status_t               status;
    logic [HASH_W-1:0]     hash;
  } intern_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_name_byte = '0;
  logic in_byte_present = 1'b0;
  logic in_last_byte = 1'b0;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [SLOT_OUT_W-1:0] out_slot_index;
  logic [1:0] out_status;
  logic [HASH_W-1:0] out_name_hash;

  symbol_intern_hash_table u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_name_byte(in_name_byte), .in_byte_present(in_byte_present),
    .in_last_byte(in_last_byte), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_slot_index(out_slot_index),
    .out_status(out_status), .out_name_hash(out_name_hash)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table.
  logic [LIMIT_W-1:0] load_limit;
  logic [7:0] name_buf_bytes [MAXLEN];
  int unsigned name_buf_len;
  logic [HASH_W-1:0] hash_acc;
  logic slot_used [SLOTS];
  logic [HASH_W-1:0] slot_hash [SLOTS];
  int unsigned slot_len [SLOTS];
  logic [7:0] slot_bytes [SLOTS][MAXLEN];
  int unsigned stored_count;

  name_beat_t beat_queue[$];
  intern_result_t expected_results[$];
  name_beat_t cur_beat;
  bit presenting = 0;
  bit taken = 0;
  bit hold_sender = 0;
  int idle_pct = 25;
  int errors = 0;
  int stall_cycles = 0;

  logic [7:0] gen_bytes [140];
  logic [7:0] pool_bytes [32][70];
  int pool_len [32];

  function automatic bit intern_step(input name_beat_t b, output intern_result_t r);
    logic [HASH_W-1:0] h;
    int unsigned len;
    int unsigned s;
    bit same;
    h = '0;
    r = '0;
    if (b.present) begin
      hash_acc = (hash_acc ^ {24'd0, b.name_byte}) * FNV_PRIME;
      if (name_buf_len < MAXLEN) name_buf_bytes[name_buf_len] = b.name_byte;
      if (name_buf_len <= MAXLEN) name_buf_len++;
    end
    if (!b.last) return 0;
    h = hash_acc;
    len = name_buf_len;
    hash_acc = FNV_BASIS;
    name_buf_len = 0;
    r.hash = h;
    r.slot = '0;
    if (len > MAXLEN) begin
      r.status = ST_TOO_LONG;
      return 1;
    end
    r.status = ST_FULL;
    s = h % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used[s]) begin
        if (stored_count < load_limit) begin
          slot_used[s] = 1'b1;
          slot_hash[s] = h;
          slot_len[s] = len;
          for (int i = 0; i < len; i++) slot_bytes[s][i] = name_buf_bytes[i];
          stored_count++;
          r.slot = s[7:0];
          r.status = ST_INSERTED;
        end
        break;
      end
      same = (slot_hash[s] == h) && (slot_len[s] == len);
      for (int i = 0; i < len && same; i++)
        if (slot_bytes[s][i] != name_buf_bytes[i]) same = 0;
      if (same) begin
        r.slot = s[7:0];
        r.status = ST_FOUND;
        break;
      end
      s = (s + 1) % SLOTS;
    end
    return 1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Sampling side: accepts beats, predicts, checks results.
  always @(posedge clk) begin
    intern_result_t r;
    intern_result_t want;
    bit moved;
    moved = 0;
    if (rst_n) begin
      if (out_valid) begin
        moved = 1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result slot %0d status %0d hash %h",
                                    out_slot_index, out_status, out_name_hash));
        end else begin
          want = expected_results.pop_front();
          if (out_slot_index !== want.slot)
            report_mismatch($sformatf("slot %0d, wanted %0d", out_slot_index, want.slot));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", out_status, want.status));
          if (out_name_hash !== want.hash)
            report_mismatch($sformatf("hash %h, wanted %h", out_name_hash, want.hash));
        end
      end
      if (start && !busy) begin
        moved = 1;
        taken = 1;
        if (intern_step(cur_beat, r)) expected_results.push_back(r);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Driving side.
  always @(negedge clk) begin
    if (rst_n && (!presenting || taken)) begin
      taken = 0;
      if (beat_queue.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
        cur_beat = beat_queue.pop_front();
        presenting = 1;
        start <= 1'b1;
        in_name_byte <= cur_beat.name_byte;
        in_byte_present <= cur_beat.present;
        in_last_byte <= cur_beat.last;
      end else begin
        presenting = 0;
        start <= 1'b0;
        in_name_byte <= 8'($urandom);
        in_byte_present <= 1'($urandom);
        in_last_byte <= 1'($urandom);
      end
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic p, input logic l);
    name_beat_t nb;
    nb.name_byte = b;
    nb.present = p;
    nb.last = l;
    beat_queue.push_back(nb);
  endtask

  // Sends gen_bytes[0..len-1] as one name; an empty name is a lone last beat.
  task automatic push_name(input int len, input bit noise);
    if (len == 0) begin
      push_beat(8'($urandom), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(19) == 0) push_beat(8'($urandom), 1'b0, 1'b0);
      push_beat(gen_bytes[i], 1'b1, i == len - 1);
    end
  endtask

  task automatic fill_random(input int len);
    for (int i = 0; i < len; i++) gen_bytes[i] = 8'($urandom);
  endtask

  task automatic drain;
    wait (beat_queue.size() == 0 && !presenting && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= LIMIT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    load_limit = LIMIT_W'(value);
  endtask

  task automatic random_names(input int count);
    int k;
    int len;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(31);
      if ($urandom_range(9) < 5 && pool_len[k] >= 0) begin
        len = pool_len[k];
        for (int i = 0; i < len; i++) gen_bytes[i] = pool_bytes[k][i];
      end else begin
        case ($urandom_range(19))
          0: len = 0;
          1: len = $urandom_range(MAXLEN + 6, MAXLEN - 2);
          default: len = $urandom_range(6, 1);
        endcase
        fill_random(len);
        if (len <= 70) begin
          pool_len[k] = len;
          for (int i = 0; i < len; i++) pool_bytes[k][i] = gen_bytes[i];
        end
      end
      push_name(len, 1'b1);
    end
  endtask

  initial begin
    load_limit = LIMIT_RESET;
    name_buf_len = 0;
    hash_acc = FNV_BASIS;
    stored_count = 0;
    for (int s = 0; s < SLOTS; s++) slot_used[s] = 1'b0;
    for (int k = 0; k < 32; k++) pool_len[k] = -1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_name(0, 0);
    push_name(0, 0);
    gen_bytes[0] = 8'h00;
    push_name(1, 0);
    gen_bytes[0] = 8'hFF;
    push_name(1, 0);
    push_name(1, 0);
    push_beat(8'h3C, 1'b0, 1'b0);
    gen_bytes[0] = 8'h00;
    push_name(1, 0);
    fill_random(MAXLEN);
    push_name(MAXLEN, 0);
    push_name(MAXLEN, 0);
    fill_random(MAXLEN + 1);
    push_name(MAXLEN + 1, 0);
    drain();

    write_limit(1);
    gen_bytes[0] = 8'hFF;
    push_name(1, 0);
    gen_bytes[0] = 8'h42;
    push_name(1, 0);
    push_name(0, 0);
    drain();

    write_limit(stored_count + 40);
    idle_pct = 25;
    random_names(12);
    wait (beat_queue.size() < 40);
    hold_sender = 1;
    wait (!presenting && expected_results.size() == 0);
    hold_sender = 0;
    drain();

    write_limit(255);
    idle_pct = 48;
    random_names(10);
    drain();

    write_limit(SLOTS);
    idle_pct = 0;
    random_names(10);
    drain();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
src/symint_pkg.sv
src/symint_ram.sv
src/symint_hash.sv
src/symint_probe.sv
src/symbol_intern_hash_table.sv
src/symint_checker.sv
tb/sv/symbol_intern_hash_table_test.sv
